// ===== src/transport_receiver_connection_table_top_defines.svh =====
// assertion macros for the connection table
`ifndef TRANSPORT_RECEIVER_CONNECTION_TABLE_TOP_DEFINES_SVH
`define TRANSPORT_RECEIVER_CONNECTION_TABLE_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TRCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, without a reset guard
`define TRCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/trct_pkg.sv =====
// package: types and constants of the connection table
`timescale 1ns / 1ps
package trct_pkg;
  localparam int NumEntries = 8;
  localparam int IdxW = $clog2(NumEntries);
  localparam logic [16:0] BufferBytes = 17'd32768;
  localparam logic [15:0] CwReset = 16'd100;

  typedef enum logic [2:0] {
    FN_OPEN = 3'd0, FN_ACCEPT = 3'd1, FN_READ = 3'd2, FN_CLOSE = 3'd3,
    FN_SEG = 3'd4, FN_TICK = 3'd5, FN_RSV6 = 3'd6, FN_RSV7 = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FAIL = 2'd1, ST_WAIT = 2'd2, ST_DROP = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MD_CLOSED = 2'd0, MD_LISTEN = 2'd1, MD_CONN = 2'd2, MD_CWAIT = 2'd3
  } mode_e;

  localparam logic [1:0] SegSyn = 2'd0;
  localparam logic [1:0] SegFin = 2'd1;
  localparam logic [1:0] SegData = 2'd2;

  typedef enum logic [2:0] {
    FS_IDLE, FS_SCAN, FS_EXEC, FS_OUT
  } fsm_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  sock_index;
    logic [15:0] local_port;
    logic [15:0] peer_port;
    logic [7:0]  peer_node;
    logic [1:0]  seg_kind;
    logic [31:0] seq_num;
    logic [15:0] byte_count;
    logic        check_ok;
  } req_t;

  typedef struct packed {
    logic [1:0]  call_status;
    logic [2:0]  sock_out;
    logic [1:0]  entry_state;
    logic        ack_valid;
    logic [1:0]  ack_kind;
    logic [15:0] ack_src_port;
    logic [15:0] ack_dest_port;
    logic [7:0]  ack_node;
    logic [31:0] ack_number;
  } rsp_t;

  // one entry of the table
  typedef struct packed {
    logic [15:0] port;
    logic [1:0]  mode;
    logic [15:0] peer_port;
    logic [7:0]  peer_node;
    logic [31:0] exp_seq;
    logic [15:0] used;
    logic [15:0] wait_cnt;
  } entry_t;

  // control from sequencer to the entry unit
  typedef struct packed {
    logic            start;
    logic            scan;
    logic [IdxW-1:0] ptr;
    logic            exec;
  } ctl_t;
endpackage

// ===== src/trct_if.sv =====
// handshake channel interface
`timescale 1ns / 1ps
interface trct_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/trct_seq.sv =====
// sequencer: walks the table one entry a cycle for each event
`timescale 1ns / 1ps
`include "transport_receiver_connection_table_top_defines.svh"
module trct_seq (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  input  logic scan_done_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output trct_pkg::ctl_t ctl_o
);
  import trct_pkg::*;
  fsm_e state_q, state_d;
  logic [IdxW-1:0] ptr_q, ptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      ptr_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    ctl_o = '0;
    ctl_o.ptr = ptr_q;
    unique case (state_q)
      FS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.start = 1'b1;
          ptr_d = '0;
          state_d = FS_SCAN;
        end
      end
      FS_SCAN: begin
        ctl_o.scan = 1'b1;
        if (scan_done_i || ptr_q == IdxW'(NumEntries - 1)) begin
          state_d = FS_EXEC;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      FS_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d = FS_OUT;
      end
      FS_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  `TRCT_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> state_q == FS_IDLE, "ready out of idle")
  `TRCT_ASSERT(a_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while result held")
  `TRCT_ASSERT(a_exec_out, clk_i, rst_ni, ctl_o.exec |=> out_valid_o, "exec not followed by result")
endmodule

// ===== src/trct_unit.sv =====
// entry unit: table storage, shared compare during scan, event update
`timescale 1ns / 1ps
`include "transport_receiver_connection_table_top_defines.svh"
module trct_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  trct_pkg::ctl_t ctl_i,
  input  trct_pkg::req_t req_i,
  input  logic cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic scan_done_o,
  output trct_pkg::rsp_t rsp_o
);
  import trct_pkg::*;
  entry_t ent_q [NumEntries];
  logic [NumEntries-1:0] vld_q, vld_d;
  logic [15:0] cw_q;
  req_t req_q;
  logic hit_q;
  logic [IdxW-1:0] hit_idx_q;
  rsp_t rsp_q;

  entry_t cur;
  logic cur_hit;
  // event-specific match at the scan pointer
  always_comb begin
    cur = ent_q[ctl_i.ptr];
    case (func_e'(req_q.func))
      FN_OPEN: cur_hit = !vld_q[ctl_i.ptr];
      FN_SEG:  cur_hit = vld_q[ctl_i.ptr] && cur.port == req_q.local_port;
      default: cur_hit = 1'b0;
    endcase
  end
  assign scan_done_o = cur_hit;

  // tick: the scan pointer entry's timer advances each scan cycle while the entry is valid and in close-wait
  logic [16:0] wc_inc;
  assign wc_inc = {1'b0, cur.wait_cnt} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= CwReset;
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) cw_q <= cfg_wdata_i;
      vld_q <= vld_d;
      if (ctl_i.start) hit_q <= 1'b0;
      else if (ctl_i.scan && cur_hit && !hit_q) hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) req_q <= req_i;
    if (ctl_i.scan && cur_hit && !hit_q) hit_idx_q <= ctl_i.ptr;
  end

  // shared datapath on the selected entry
  logic [IdxW-1:0] sel;
  entry_t e, e_n;
  rsp_t r;
  logic sel_ok, do_wr, scanning;
  logic [16:0] sum;
  logic [IdxW-1:0] sidx;
  assign scanning = ctl_i.scan;
  always_comb begin
    sidx = IdxW'(req_q.sock_index);
    sel = (func_e'(req_q.func) == FN_OPEN || func_e'(req_q.func) == FN_SEG) ? hit_idx_q : sidx;
    sel_ok = ({29'd0, req_q.sock_index} < NumEntries) && vld_q[sidx];
    e = ent_q[sel];
    e_n = e;
    r = '0;
    r.call_status = ST_FAIL;
    do_wr = 1'b0;
    vld_d = vld_q;
    sum = {1'b0, e.used} + {1'b0, req_q.byte_count};
    if (ctl_i.exec) begin
      case (func_e'(req_q.func))
        FN_OPEN: if (hit_q) begin
          vld_d[sel] = 1'b1;
          e_n = '0;
          e_n.port = req_q.local_port;
          do_wr = 1'b1;
          r.call_status = ST_OK;
          r.sock_out = 3'(sel);
        end
        FN_ACCEPT: if (sel_ok) begin
          if (e.mode == MD_CONN) r.call_status = ST_OK;
          else begin
            e_n.mode = MD_LISTEN;
            r.call_status = ST_WAIT;
            do_wr = 1'b1;
          end
          r.entry_state = e_n.mode;
        end
        FN_READ: if (sel_ok) begin
          r.entry_state = e.mode;
          if (e.mode == MD_CONN) begin
            if (e.used >= req_q.byte_count) begin
              e_n.used = e.used - req_q.byte_count;
              do_wr = 1'b1;
              r.call_status = ST_OK;
            end else r.call_status = ST_WAIT;
          end
        end
        FN_CLOSE: if (sel_ok) begin
          r.entry_state = e.mode;
          r.call_status = (e.mode == MD_CLOSED) ? ST_OK : ST_FAIL;
          vld_d[sel] = 1'b0;
          e_n.used = '0;
          do_wr = 1'b1;
        end
        FN_SEG: begin
          r.call_status = ST_DROP;
          if (req_q.check_ok && req_q.seg_kind != 2'd3 && hit_q) begin
            do_wr = 1'b1;
            e_n.peer_port = req_q.peer_port;
            r.call_status = ST_FAIL;
            if (req_q.seg_kind == SegSyn) begin
              if (e.mode == MD_LISTEN || e.mode == MD_CONN) begin
                e_n.mode = MD_CONN;
                e_n.peer_node = req_q.peer_node;
                e_n.exp_seq = req_q.seq_num;
                r.ack_kind = SegSyn;
                r.ack_valid = 1'b1;
              end
            end else if (req_q.seg_kind == SegFin) begin
              if (e.mode == MD_CONN || e.mode == MD_CWAIT) begin
                if (e.mode == MD_CONN) e_n.wait_cnt = '0;
                e_n.mode = MD_CWAIT;
                r.ack_kind = SegFin;
                r.ack_valid = 1'b1;
              end
            end else if (e.mode == MD_CONN) begin
              if (e.exp_seq == req_q.seq_num && sum < BufferBytes) begin
                e_n.exp_seq = e.exp_seq + {16'd0, req_q.byte_count};
                e_n.used = sum[15:0];
              end
              r.ack_kind = SegData;
              r.ack_valid = 1'b1;
              r.ack_number = e_n.exp_seq;
            end
            if (r.ack_valid) begin
              r.call_status = ST_OK;
              r.ack_src_port = e_n.port;
              r.ack_dest_port = e_n.peer_port;
              r.ack_node = e_n.peer_node;
            end
            r.entry_state = e_n.mode;
          end
        end
        FN_TICK: r.call_status = ST_OK;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      rsp_q <= r;
      if (do_wr) ent_q[sel] <= e_n;
    end else if (scanning && func_e'(req_q.func) == FN_TICK && vld_q[ctl_i.ptr]
                 && cur.mode == MD_CWAIT) begin
      if (wc_inc >= {1'b0, cw_q}) begin
        ent_q[ctl_i.ptr].mode <= MD_CLOSED;
        ent_q[ctl_i.ptr].wait_cnt <= '0;
      end else begin
        ent_q[ctl_i.ptr].wait_cnt <= wc_inc[15:0];
      end
    end
  end
  assign rsp_o = rsp_q;

  `TRCT_ASSERT(a_open_free, clk_i, rst_ni, (ctl_i.exec && func_e'(req_q.func) == FN_OPEN && hit_q) |-> !vld_q[hit_idx_q], "open on busy entry")
  `TRCT_ASSERT(a_vld_stable, clk_i, rst_ni, !ctl_i.exec |=> $stable(vld_q), "valid bits change outside exec")
  `TRCT_ASSERT(a_ack_ok, clk_i, rst_ni, (ctl_i.exec && r.ack_valid) |-> r.call_status == ST_OK, "ack without success")
endmodule

// ===== src/transport_receiver_connection_table_top.sv =====
// top level of the go-back-N receiver connection table
`timescale 1ns / 1ps
// Server-side connection table for a go-back-N transport, eight entries.
// in_ch (sink): one event per beat: open, accept, read, close, segment, tick.
// out_ch (source): exactly one result beat per event, with status, granted
//   entry, entry mode and the reply segment header when ack_valid is set.
// cfg_we_i/cfg_wdata_i write closewait_ticks; write only while idle.
// Each event passes from accept to result valid through a sequential scan
//   that visits one table entry per cycle (open and segment stop at the
//   first match, other events walk all entries), then an update on the
//   selected entry. The block is ready for the next event in the cycle
//   after the result beat leaves.
// in_ch.ready is high only while idle; a stalled out_ch holds the result
//   and the block takes no new event.
// Reset frees all entries and sets closewait_ticks to 100; entry contents
//   are only read after an open has written them.
module transport_receiver_connection_table_top (
  input  logic clk_i,
  input  logic rst_ni,
  trct_if.sink   in_ch,
  trct_if.source out_ch,
  input  logic cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import trct_pkg::*;
  ctl_t ctl;
  logic scan_done;

  trct_seq u_seq (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .out_ready_i(out_ch.ready),
    .scan_done_i(scan_done), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .ctl_o(ctl)
  );

  trct_unit u_unit (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl), .req_i(in_ch.data),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .scan_done_o(scan_done), .rsp_o(out_ch.data)
  );
endmodule
